// ===== sv/kte_pkg.sv =====
package kte_pkg;

    localparam int MAX_KEYS_DEF     = 64;
    localparam int NEWTON_STEPS_DEF = 8;

    localparam int TIME_W  = 40;
    localparam int VAL_W   = 32;
    localparam int CTRL_W  = 16;
    localparam int SEG_W   = 6;
    localparam int KCNT_W  = 7;
    localparam int IN_W    = 144;
    localparam int OUT_W   = 40;

    // datapath widths
    localparam int COEF_W  = 24;
    localparam int ACC_W   = 42;
    localparam int MULA_W  = 34;
    localparam int PROD_W  = MULA_W + COEF_W;
    localparam int FRAC_W  = 17;
    localparam int ERR_W   = 26;
    localparam int DIVN_W  = 57;
    localparam int DIVD_W  = 40;
    localparam int DIV_BITS = 19;
    localparam int DIVC_W  = 5;

    localparam logic signed [COEF_W-1:0] ONE_Q16 = 24'sd65536;

    localparam logic       OP_LOAD = 1'b0;
    localparam logic       OP_EVAL = 1'b1;
    localparam logic [1:0] EASE_LINEAR = 2'd0;
    localparam logic [1:0] EASE_BEZIER = 2'd1;
    localparam logic [1:0] EASE_HOLD   = 2'd2;

    typedef struct packed {
        logic [CTRL_W-1:0] ctrl2_y;
        logic [CTRL_W-1:0] ctrl2_x;
        logic [CTRL_W-1:0] ctrl1_y;
        logic [CTRL_W-1:0] ctrl1_x;
        logic [1:0]        easing;
        logic [VAL_W-1:0]  kval;
        logic [TIME_W-1:0] tstamp;
    } key_entry_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_START, ST_RD0, ST_RDL, ST_SCAN, ST_DIVF,
        ST_NX0, ST_NX1, ST_NX2, ST_NX3, ST_NX4, ST_NX5, ST_NX6,
        ST_NX7, ST_NX8, ST_NX9, ST_NX10, ST_NX11, ST_NX12, ST_NX13,
        ST_NY0, ST_NY1, ST_NY2, ST_NY3, ST_NY4, ST_NY5, ST_NY6, ST_NY7,
        ST_FIN0, ST_FIN1, ST_FIN2, ST_EMIT
    } state_t;

    typedef enum logic [1:0] {S_HOLD, S_LOAD, S_ADD} s_op_t;
    typedef enum logic [1:0] {SRC_AX, SRC_AX3, SRC_AY, SRC_DIFF} s_src_t;
    typedef enum logic [2:0] {
        ADD_BX, ADD_BX2, ADD_CX, ADD_NEGF, ADD_BY, ADD_CY, ADD_ZERO, ADD_PV
    } add_sel_t;
    typedef enum logic {DIV_FRAC, DIV_NEWTON} div_sel_t;
    typedef enum logic {MULB_T, MULB_EASE} mulb_sel_t;
    typedef enum logic {EASRC_F, EASRC_S} ease_src_t;
    typedef enum logic [1:0] {RES_EMPTY, RES_RD, RES_PREV, RES_SAT} res_sel_t;

    typedef struct packed {
        logic       mem_we;
        logic       q_ld;
        logic       rd_en;
        logic       prev_ld;
        logic       coef_ld;
        logic       div_start;
        div_sel_t   div_sel;
        logic       f_ld;
        logic       t_upd;
        logic       err_ld;
        logic       ease_ld;
        ease_src_t  ease_src;
        s_op_t      s_op;
        s_src_t     s_src;
        add_sel_t   add_sel;
        logic       mul_en;
        mulb_sel_t  mulb_sel;
        logic       out_ld;
        res_sel_t   res_sel;
        logic [SEG_W-1:0] seg;
    } cmd_t;

    typedef struct packed {
        logic       q_le_rd;
        logic       q_ge_rd;
        logic       s_zero;
        logic       div_busy;
        logic [1:0] easing;
    } stat_t;

endpackage

// ===== sv/kte_dp.sv =====
module kte_dp #(
    parameter int MAX_KEYS = kte_pkg::MAX_KEYS_DEF,
    parameter int IW       = $clog2(MAX_KEYS)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [kte_pkg::IN_W-1:0]    s_tdata,
    input  kte_pkg::cmd_t               cmd,
    input  logic [IW-1:0]               rd_addr,
    output kte_pkg::stat_t              stat,
    output logic [kte_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tuser
);

    localparam int SW = kte_pkg::ACC_W;
    localparam int CW = kte_pkg::COEF_W;

    kte_pkg::key_entry_t mem [MAX_KEYS];
    kte_pkg::key_entry_t wr_entry;
    kte_pkg::key_entry_t rd_reg, prev_reg;
    logic [5:0]          in_slot;

    logic [kte_pkg::TIME_W-1:0] q_reg;
    logic signed [CW-1:0] ax_reg, bx_reg, cx_reg, ay_reg, by_reg, cy_reg;
    logic signed [CW-1:0] ax_next, bx_next, cx_next, ay_next, by_next, cy_next;
    logic signed [CW-1:0] x1, x2, y1, y2;
    logic [kte_pkg::FRAC_W-1:0] f_reg, t_reg, t_next;
    logic signed [SW-1:0] s_reg, s_next, addend, s_abs;
    logic signed [kte_pkg::PROD_W-1:0] prod_reg;
    logic signed [CW-1:0] mul_b;
    logic signed [kte_pkg::ERR_W-1:0] err_reg;
    logic [kte_pkg::ERR_W-1:0] err_mag;
    logic signed [CW-1:0] ease_reg;
    logic signed [32:0]   diff_v;

    // restoring divider
    logic [kte_pkg::DIVN_W-1:0] div_num;
    logic [kte_pkg::DIVD_W-1:0] div_den, div_den_reg, div_rem_reg, div_rem_next;
    logic                       div_neg, div_neg_reg, div_ovf_reg, div_busy_reg;
    logic [kte_pkg::DIV_BITS-1:0] div_lo_reg, div_quot_reg;
    logic [kte_pkg::DIVC_W-1:0] div_cnt_reg;
    logic [kte_pkg::DIVD_W:0]   div_trial;
    logic                       div_ge;

    logic [19:0]        q_mag;
    logic signed [20:0] q_sgn, t_new;

    logic [kte_pkg::VAL_W-1:0] val_reg, val_next;
    logic                      status_reg;
    logic [kte_pkg::SEG_W-1:0] seg_reg;

    assign in_slot           = s_tdata[5:0];
    assign wr_entry.tstamp   = s_tdata[45:6];
    assign wr_entry.kval     = s_tdata[77:46];
    assign wr_entry.easing   = s_tdata[79:78];
    assign wr_entry.ctrl1_x  = s_tdata[95:80];
    assign wr_entry.ctrl1_y  = s_tdata[111:96];
    assign wr_entry.ctrl2_x  = s_tdata[127:112];
    assign wr_entry.ctrl2_y  = s_tdata[143:128];

    always_ff @(posedge aclk) begin
        if (cmd.mem_we && (int'(in_slot) < MAX_KEYS)) begin
            mem[IW'(in_slot)] <= wr_entry;
        end
        if (cmd.rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Bezier coefficients, control points scaled to Q16
    always_comb begin
        x1 = CW'({rd_reg.ctrl1_x, 1'b0});
        x2 = CW'({rd_reg.ctrl2_x, 1'b0});
        y1 = CW'($signed({rd_reg.ctrl1_y, 2'b00}));
        y2 = CW'($signed({rd_reg.ctrl2_y, 2'b00}));
        cx_next = x1 * CW'(3);
        bx_next = (x2 - x1) * CW'(3) - cx_next;
        ax_next = kte_pkg::ONE_Q16 - cx_next - bx_next;
        cy_next = y1 * CW'(3);
        by_next = (y2 - y1) * CW'(3) - cy_next;
        ay_next = kte_pkg::ONE_Q16 - cy_next - by_next;
    end

    assign diff_v = $signed({rd_reg.kval[31], rd_reg.kval})
                  - $signed({prev_reg.kval[31], prev_reg.kval});

    always_comb begin
        case (cmd.add_sel)
            kte_pkg::ADD_BX:   addend = SW'(bx_reg);
            kte_pkg::ADD_BX2:  addend = SW'(bx_reg) <<< 1;
            kte_pkg::ADD_CX:   addend = SW'(cx_reg);
            kte_pkg::ADD_NEGF: addend = -$signed(SW'(f_reg));
            kte_pkg::ADD_BY:   addend = SW'(by_reg);
            kte_pkg::ADD_CY:   addend = SW'(cy_reg);
            kte_pkg::ADD_PV:   addend = SW'($signed(prev_reg.kval));
            default:           addend = '0;
        endcase
        s_next = s_reg;
        case (cmd.s_op)
            kte_pkg::S_LOAD: begin
                case (cmd.s_src)
                    kte_pkg::SRC_AX:  s_next = SW'(ax_reg);
                    kte_pkg::SRC_AX3: s_next = SW'(ax_reg) * 3;
                    kte_pkg::SRC_AY:  s_next = SW'(ay_reg);
                    default:          s_next = SW'(diff_v);
                endcase
            end
            kte_pkg::S_ADD: s_next = prod_reg[kte_pkg::PROD_W-1:16] + addend;
            default:        s_next = s_reg;
        endcase
    end

    assign mul_b = (cmd.mulb_sel == kte_pkg::MULB_EASE) ? ease_reg : CW'(t_reg);

    // divider operand selection
    assign err_mag = err_reg[kte_pkg::ERR_W-1] ? kte_pkg::ERR_W'(-err_reg)
                                                : kte_pkg::ERR_W'(err_reg);
    assign s_abs   = s_reg[SW-1] ? -s_reg : s_reg;
    always_comb begin
        if (cmd.div_sel == kte_pkg::DIV_FRAC) begin
            div_num = kte_pkg::DIVN_W'({q_reg - prev_reg.tstamp, 16'h0000});
            div_den = rd_reg.tstamp - prev_reg.tstamp;
            div_neg = 1'b0;
        end else begin
            div_num = kte_pkg::DIVN_W'({err_mag, 16'h0000});
            div_den = s_abs[kte_pkg::DIVD_W-1:0];
            div_neg = err_reg[kte_pkg::ERR_W-1] ^ s_reg[SW-1];
        end
    end

    assign div_trial    = {div_rem_reg, div_lo_reg[kte_pkg::DIV_BITS-1]};
    assign div_ge       = div_trial >= {1'b0, div_den_reg};
    assign div_rem_next = div_ge ? kte_pkg::DIVD_W'(div_trial - {1'b0, div_den_reg})
                                 : div_trial[kte_pkg::DIVD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
        end else if (cmd.div_start) begin
            div_busy_reg <= 1'b1;
        end else if (div_busy_reg && (div_cnt_reg == kte_pkg::DIVC_W'(kte_pkg::DIV_BITS - 1))) begin
            div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            div_rem_reg <= kte_pkg::DIVD_W'(div_num[kte_pkg::DIVN_W-1:kte_pkg::DIV_BITS]);
            div_lo_reg  <= div_num[kte_pkg::DIV_BITS-1:0];
            div_den_reg <= div_den;
            div_ovf_reg <= kte_pkg::DIVD_W'(div_num[kte_pkg::DIVN_W-1:kte_pkg::DIV_BITS])
                           >= div_den;
            div_neg_reg <= div_neg;
            div_cnt_reg <= '0;
            div_quot_reg <= '0;
        end else if (div_busy_reg) begin
            div_rem_reg  <= div_rem_next;
            div_lo_reg   <= div_lo_reg << 1;
            div_quot_reg <= {div_quot_reg[kte_pkg::DIV_BITS-2:0], div_ge};
            div_cnt_reg  <= div_cnt_reg + 1'b1;
        end
    end

    // Newton update: quotient beyond 2^19 always clamps, so it saturates there
    always_comb begin
        q_mag = div_ovf_reg ? 20'h80000 : {1'b0, div_quot_reg};
        q_sgn = div_neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        t_new = $signed({4'b0000, t_reg}) - q_sgn;
        if (t_new < 0) begin
            t_next = '0;
        end else if (t_new > 21'sd65536) begin
            t_next = 17'h10000;
        end else begin
            t_next = t_new[kte_pkg::FRAC_W-1:0];
        end
    end

    always_comb begin
        case (cmd.res_sel)
            kte_pkg::RES_RD:   val_next = rd_reg.kval;
            kte_pkg::RES_PREV: val_next = prev_reg.kval;
            kte_pkg::RES_SAT: begin
                if (s_reg > SW'(32'sh7fffffff)) begin
                    val_next = 32'h7fffffff;
                end else if (s_reg < -SW'(33'sh080000000)) begin
                    val_next = 32'h80000000;
                end else begin
                    val_next = s_reg[31:0];
                end
            end
            default:           val_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.q_ld) begin
            q_reg <= s_tdata[45:6];
        end
        if (cmd.prev_ld) begin
            prev_reg <= rd_reg;
        end
        if (cmd.coef_ld) begin
            ax_reg <= ax_next;
            bx_reg <= bx_next;
            cx_reg <= cx_next;
            ay_reg <= ay_next;
            by_reg <= by_next;
            cy_reg <= cy_next;
        end
        if (cmd.f_ld) begin
            f_reg <= div_quot_reg[kte_pkg::FRAC_W-1:0];
            t_reg <= div_quot_reg[kte_pkg::FRAC_W-1:0];
        end else if (cmd.t_upd) begin
            t_reg <= t_next;
        end
        if (cmd.err_ld) begin
            err_reg <= s_reg[kte_pkg::ERR_W-1:0];
        end
        if (cmd.ease_ld) begin
            ease_reg <= (cmd.ease_src == kte_pkg::EASRC_F)
                        ? CW'(div_quot_reg[kte_pkg::FRAC_W-1:0]) : s_reg[CW-1:0];
        end
        s_reg <= s_next;
        if (cmd.mul_en) begin
            prod_reg <= $signed(s_reg[kte_pkg::MULA_W-1:0]) * mul_b;
        end
        if (cmd.out_ld) begin
            val_reg    <= val_next;
            status_reg <= (cmd.res_sel == kte_pkg::RES_EMPTY);
            seg_reg    <= cmd.seg;
        end
    end

    assign stat.q_le_rd  = q_reg <= rd_reg.tstamp;
    assign stat.q_ge_rd  = q_reg >= rd_reg.tstamp;
    assign stat.s_zero   = (s_reg == '0);
    assign stat.div_busy = div_busy_reg;
    assign stat.easing   = rd_reg.easing;

    assign m_tdata = {2'b00, seg_reg, val_reg};
    assign m_tuser = status_reg;

endmodule

// ===== sv/kte_ctrl.sv =====
module kte_ctrl #(
    parameter int MAX_KEYS     = kte_pkg::MAX_KEYS_DEF,
    parameter int NEWTON_STEPS = kte_pkg::NEWTON_STEPS_DEF,
    parameter int IW           = $clog2(MAX_KEYS)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_op,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic                        cfg_we,
    input  logic [kte_pkg::KCNT_W-1:0]  cfg_wdata,
    input  kte_pkg::stat_t              stat,
    output kte_pkg::cmd_t               cmd,
    output logic [IW-1:0]               rd_addr
);

    localparam int NW = $clog2(MAX_KEYS + 1);
    localparam int KW = $clog2(NEWTON_STEPS + 1);

    kte_pkg::state_t   state_reg, state_next;
    kte_pkg::res_sel_t res_sel_reg, res_sel_next;
    logic [kte_pkg::SEG_W-1:0] seg_reg, seg_next;
    logic [kte_pkg::KCNT_W-1:0] key_count_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic [KW-1:0] k_reg, k_next;
    logic          out_valid_reg;
    logic [NW-1:0] n_w, n_last;
    logic          out_free, accept;

    assign n_w = (int'(key_count_reg) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(key_count_reg);
    assign n_last   = n_w - NW'(1);
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == kte_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= kte_pkg::ST_IDLE;
            key_count_reg <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            k_reg         <= '0;
            res_sel_reg   <= kte_pkg::RES_EMPTY;
            seg_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            k_reg       <= k_next;
            res_sel_reg <= res_sel_next;
            seg_reg     <= seg_next;
            if (cfg_we) begin
                key_count_reg <= cfg_wdata;
            end
            if (cmd.out_ld) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // next state
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        res_sel_next = res_sel_reg;
        seg_next     = seg_reg;
        case (state_reg)
            kte_pkg::ST_IDLE: begin
                if (accept && (s_op == kte_pkg::OP_EVAL)) begin
                    state_next = kte_pkg::ST_START;
                end
            end
            kte_pkg::ST_START: begin
                if (n_w == '0) begin
                    res_sel_next = kte_pkg::RES_EMPTY;
                    seg_next     = '0;
                    state_next   = kte_pkg::ST_EMIT;
                end else begin
                    state_next = kte_pkg::ST_RD0;
                end
            end
            kte_pkg::ST_RD0: begin
                if ((n_w == NW'(1)) || stat.q_le_rd) begin
                    res_sel_next = kte_pkg::RES_RD;
                    seg_next     = '0;
                    state_next   = kte_pkg::ST_EMIT;
                end else begin
                    state_next = kte_pkg::ST_RDL;
                end
            end
            kte_pkg::ST_RDL: begin
                if (stat.q_ge_rd) begin
                    res_sel_next = kte_pkg::RES_RD;
                    seg_next     = kte_pkg::SEG_W'(n_last);
                    state_next   = kte_pkg::ST_EMIT;
                end else begin
                    idx_next   = IW'(1);
                    state_next = kte_pkg::ST_SCAN;
                end
            end
            kte_pkg::ST_SCAN: begin
                if (stat.q_le_rd) begin
                    seg_next = kte_pkg::SEG_W'(idx_reg);
                    if (stat.easing == kte_pkg::EASE_HOLD) begin
                        res_sel_next = kte_pkg::RES_PREV;
                        state_next   = kte_pkg::ST_EMIT;
                    end else begin
                        state_next = kte_pkg::ST_DIVF;
                    end
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            kte_pkg::ST_DIVF: begin
                if (!stat.div_busy) begin
                    k_next = '0;
                    state_next = (stat.easing == kte_pkg::EASE_BEZIER)
                                 ? kte_pkg::ST_NX0 : kte_pkg::ST_FIN0;
                end
            end
            kte_pkg::ST_NX0:  state_next = kte_pkg::ST_NX1;
            kte_pkg::ST_NX1:  state_next = kte_pkg::ST_NX2;
            kte_pkg::ST_NX2:  state_next = kte_pkg::ST_NX3;
            kte_pkg::ST_NX3:  state_next = kte_pkg::ST_NX4;
            kte_pkg::ST_NX4:  state_next = kte_pkg::ST_NX5;
            kte_pkg::ST_NX5:  state_next = kte_pkg::ST_NX6;
            kte_pkg::ST_NX6:  state_next = kte_pkg::ST_NX7;
            kte_pkg::ST_NX7:  state_next = stat.s_zero ? kte_pkg::ST_NY0 : kte_pkg::ST_NX8;
            kte_pkg::ST_NX8:  state_next = kte_pkg::ST_NX9;
            kte_pkg::ST_NX9:  state_next = kte_pkg::ST_NX10;
            kte_pkg::ST_NX10: state_next = kte_pkg::ST_NX11;
            kte_pkg::ST_NX11: state_next = kte_pkg::ST_NX12;
            kte_pkg::ST_NX12: state_next = stat.s_zero ? kte_pkg::ST_NY0 : kte_pkg::ST_NX13;
            kte_pkg::ST_NX13: begin
                if (!stat.div_busy) begin
                    if (k_reg == KW'(NEWTON_STEPS - 1)) begin
                        state_next = kte_pkg::ST_NY0;
                    end else begin
                        k_next     = k_reg + KW'(1);
                        state_next = kte_pkg::ST_NX0;
                    end
                end
            end
            kte_pkg::ST_NY0:  state_next = kte_pkg::ST_NY1;
            kte_pkg::ST_NY1:  state_next = kte_pkg::ST_NY2;
            kte_pkg::ST_NY2:  state_next = kte_pkg::ST_NY3;
            kte_pkg::ST_NY3:  state_next = kte_pkg::ST_NY4;
            kte_pkg::ST_NY4:  state_next = kte_pkg::ST_NY5;
            kte_pkg::ST_NY5:  state_next = kte_pkg::ST_NY6;
            kte_pkg::ST_NY6:  state_next = kte_pkg::ST_NY7;
            kte_pkg::ST_NY7:  state_next = kte_pkg::ST_FIN0;
            kte_pkg::ST_FIN0: state_next = kte_pkg::ST_FIN1;
            kte_pkg::ST_FIN1: state_next = kte_pkg::ST_FIN2;
            kte_pkg::ST_FIN2: begin
                res_sel_next = kte_pkg::RES_SAT;
                state_next   = kte_pkg::ST_EMIT;
            end
            kte_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = kte_pkg::ST_IDLE;
                end
            end
            default: state_next = kte_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd     = '0;
        rd_addr = '0;
        cmd.res_sel = res_sel_reg;
        cmd.seg     = seg_reg;
        case (state_reg)
            kte_pkg::ST_IDLE: begin
                cmd.mem_we = accept && (s_op == kte_pkg::OP_LOAD);
                cmd.q_ld   = accept && (s_op == kte_pkg::OP_EVAL);
            end
            kte_pkg::ST_START: begin
                cmd.rd_en = (n_w != '0);
            end
            kte_pkg::ST_RD0: begin
                if (!((n_w == NW'(1)) || stat.q_le_rd)) begin
                    cmd.rd_en   = 1'b1;
                    cmd.prev_ld = 1'b1;
                    rd_addr     = IW'(n_last);
                end
            end
            kte_pkg::ST_RDL: begin
                cmd.rd_en = !stat.q_ge_rd;
                rd_addr   = IW'(1);
            end
            kte_pkg::ST_SCAN: begin
                if (stat.q_le_rd) begin
                    if (stat.easing != kte_pkg::EASE_HOLD) begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = kte_pkg::DIV_FRAC;
                        cmd.coef_ld   = 1'b1;
                    end
                end else begin
                    cmd.prev_ld = 1'b1;
                    cmd.rd_en   = 1'b1;
                    rd_addr     = idx_reg + IW'(1);
                end
            end
            kte_pkg::ST_DIVF: begin
                if (!stat.div_busy) begin
                    cmd.f_ld     = 1'b1;
                    cmd.ease_ld  = (stat.easing != kte_pkg::EASE_BEZIER);
                    cmd.ease_src = kte_pkg::EASRC_F;
                end
            end
            kte_pkg::ST_NX0: begin
                cmd.s_op  = kte_pkg::S_LOAD;
                cmd.s_src = kte_pkg::SRC_AX;
            end
            kte_pkg::ST_NX2: begin
                cmd.s_op    = kte_pkg::S_ADD;
                cmd.add_sel = kte_pkg::ADD_BX;
            end
            kte_pkg::ST_NX4, kte_pkg::ST_NX11: begin
                cmd.s_op    = kte_pkg::S_ADD;
                cmd.add_sel = kte_pkg::ADD_CX;
            end
            kte_pkg::ST_NX6: begin
                cmd.s_op    = kte_pkg::S_ADD;
                cmd.add_sel = kte_pkg::ADD_NEGF;
            end
            kte_pkg::ST_NX7: begin
                cmd.err_ld = 1'b1;
                if (!stat.s_zero) begin
                    cmd.s_op  = kte_pkg::S_LOAD;
                    cmd.s_src = kte_pkg::SRC_AX3;
                end
            end
            kte_pkg::ST_NX9: begin
                cmd.s_op    = kte_pkg::S_ADD;
                cmd.add_sel = kte_pkg::ADD_BX2;
            end
            kte_pkg::ST_NX12: begin
                cmd.div_start = !stat.s_zero;
                cmd.div_sel   = kte_pkg::DIV_NEWTON;
            end
            kte_pkg::ST_NX13: begin
                cmd.t_upd = !stat.div_busy;
            end
            kte_pkg::ST_NX1, kte_pkg::ST_NX3, kte_pkg::ST_NX5, kte_pkg::ST_NX8,
            kte_pkg::ST_NX10, kte_pkg::ST_NY1, kte_pkg::ST_NY3, kte_pkg::ST_NY5: begin
                cmd.mul_en   = 1'b1;
                cmd.mulb_sel = kte_pkg::MULB_T;
            end
            kte_pkg::ST_NY0: begin
                cmd.s_op  = kte_pkg::S_LOAD;
                cmd.s_src = kte_pkg::SRC_AY;
            end
            kte_pkg::ST_NY2: begin
                cmd.s_op    = kte_pkg::S_ADD;
                cmd.add_sel = kte_pkg::ADD_BY;
            end
            kte_pkg::ST_NY4: begin
                cmd.s_op    = kte_pkg::S_ADD;
                cmd.add_sel = kte_pkg::ADD_CY;
            end
            kte_pkg::ST_NY6: begin
                cmd.s_op    = kte_pkg::S_ADD;
                cmd.add_sel = kte_pkg::ADD_ZERO;
            end
            kte_pkg::ST_NY7: begin
                cmd.ease_ld  = 1'b1;
                cmd.ease_src = kte_pkg::EASRC_S;
            end
            kte_pkg::ST_FIN0: begin
                cmd.s_op  = kte_pkg::S_LOAD;
                cmd.s_src = kte_pkg::SRC_DIFF;
            end
            kte_pkg::ST_FIN1: begin
                cmd.mul_en   = 1'b1;
                cmd.mulb_sel = kte_pkg::MULB_EASE;
            end
            kte_pkg::ST_FIN2: begin
                cmd.s_op    = kte_pkg::S_ADD;
                cmd.add_sel = kte_pkg::ADD_PV;
            end
            kte_pkg::ST_EMIT: begin
                cmd.out_ld = out_free;
            end
            default: cmd.out_ld = 1'b0;
        endcase
    end

    a_eval_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_op == kte_pkg::OP_EVAL)) |=> (state_reg == kte_pkg::ST_START))
        else $error("evaluate transaction did not start a search");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kte_pkg::ST_SCAN) |-> (int'(idx_reg) < int'(n_w)))
        else $error("segment scan ran past the last key");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten before it was taken");

    a_newton_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kte_pkg::ST_NX0) |-> (int'(k_reg) < NEWTON_STEPS))
        else $error("Newton iteration count exceeded");

    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider restarted while busy");

endmodule

// ===== sv/keyframe_track_evaluator_top.sv =====
// Keyframe track evaluator. A load transaction (s_tuser = 0) writes one keyframe into a slot;
// an evaluate transaction (s_tuser = 1) returns one interpolated Q16.16 value.
// An evaluate walks the keyframe RAM one slot per cycle to find the segment, and unless the
// segment holds, runs the span fraction through a 19-step restoring divider; for Bezier
// easing it performs up to NEWTON_STEPS Newton steps (a shared multiplier plus the same
// divider), then curve and blend arithmetic and the output load.
// Clamped and empty cases give their result without the scan.
// The input side stays busy until its result is in the output register.
// key_count (cfg_wdata) is written through cfg_we; the user must do so only while no evaluate
// is in flight, as the block itself does not enforce it.
module keyframe_track_evaluator_top #(
    parameter int MAX_KEYS     = kte_pkg::MAX_KEYS_DEF,
    parameter int NEWTON_STEPS = kte_pkg::NEWTON_STEPS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // slot, stamp_us, key_value, easing, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
    input  logic [kte_pkg::IN_W-1:0]    s_tdata,
    // op
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // result_value, segment_index
    output logic [kte_pkg::OUT_W-1:0]   m_tdata,
    // status
    output logic                        m_tuser,
    input  logic                        cfg_we,
    input  logic [kte_pkg::KCNT_W-1:0]  cfg_wdata
);

    localparam int IW = $clog2(MAX_KEYS);

    kte_pkg::cmd_t  cmd;
    kte_pkg::stat_t stat;
    logic [IW-1:0]  rd_addr;

    kte_ctrl #(
        .MAX_KEYS     (MAX_KEYS),
        .NEWTON_STEPS (NEWTON_STEPS),
        .IW           (IW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_op      (s_tuser),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stat      (stat),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    kte_dp #(
        .MAX_KEYS (MAX_KEYS),
        .IW       (IW)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .stat    (stat),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

// ===== bench/tb_keyframe_track_evaluator_top.sv =====
module tb_keyframe_track_evaluator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 400;
    localparam logic [1:0] EASE_ALT = 2'd3;  // unused code, behaves as linear

    typedef struct packed {
        logic signed [31:0] value;
        logic               status;
        logic [5:0]         seg;
    } track_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [kte_pkg::IN_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [kte_pkg::OUT_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_we = 1'b0;
    logic [kte_pkg::KCNT_W-1:0] cfg_wdata = '0;

    keyframe_track_evaluator_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // predictor state
    logic [39:0] kf_time [64];
    logic [31:0] kf_val [64];
    logic [1:0]  kf_ease [64];
    logic [63:0] kf_ctrl [64];
    bit          kf_written [64];
    int          kf_count = 0;

    track_out_t expected_vals[$];
    int errors = 0;
    int n_results = 0;
    int n_items = 0;
    bit no_idle = 1'b0;
    int hold_left = 0;

    initial forever #5 aclk = ~aclk;

    initial begin
        #100ms;
        $display("tb_keyframe_track_evaluator_top failed");
        $finish;
    end

    function automatic longint cubic_q16(longint a, longint b, longint c, longint t);
        longint s;
        s = ((a * t) >>> 16) + b;
        s = ((s * t) >>> 16) + c;
        return (s * t) >>> 16;
    endfunction

    function automatic longint bezier_ease(logic [63:0] ctl, longint f);
        longint x1, y1, x2, y2, cx, bx, ax, cy, by, ay, t, err, slope;
        x1 = longint'(ctl[15:0]) * 2;
        y1 = longint'($signed(ctl[31:16])) * 4;
        x2 = longint'(ctl[47:32]) * 2;
        y2 = longint'($signed(ctl[63:48])) * 4;
        cx = 3 * x1; bx = 3 * (x2 - x1) - cx; ax = 65536 - cx - bx;
        cy = 3 * y1; by = 3 * (y2 - y1) - cy; ay = 65536 - cy - by;
        t = f;
        for (int k = 0; k < kte_pkg::NEWTON_STEPS_DEF; k++) begin
            err = cubic_q16(ax, bx, cx, t) - f;
            if (err == 0) break;
            slope = ((((3 * ax * t) >>> 16) + 2 * bx) * t >>> 16) + cx;
            if (slope == 0) break;
            t = t - (err * 65536) / slope;
            if (t < 0) t = 0;
            if (t > 65536) t = 65536;
        end
        return cubic_q16(ay, by, cy, t);
    endfunction

    function automatic track_out_t eval_track(logic [39:0] q);
        track_out_t r;
        int n, i;
        longint pv, nv, f, ease, v;
        n = (kf_count > 64) ? 64 : kf_count;
        r.status = 1'b0;
        if (n == 0) begin
            r.value = 0; r.status = 1'b1; r.seg = 0;
            return r;
        end
        if (n == 1 || q <= kf_time[0]) begin
            r.value = kf_val[0]; r.seg = 0;
            return r;
        end
        if (q >= kf_time[n-1]) begin
            r.value = kf_val[n-1]; r.seg = 6'(n - 1);
            return r;
        end
        for (i = 1; i < n - 1; i++)
            if (kf_time[i] >= q) break;
        f = longint'({24'd0, q - kf_time[i-1]} << 16) / longint'({24'd0, kf_time[i] - kf_time[i-1]});
        pv = longint'($signed(kf_val[i-1]));
        nv = longint'($signed(kf_val[i]));
        r.seg = 6'(i);
        if (kf_ease[i] == kte_pkg::EASE_HOLD) begin
            r.value = 32'(pv);
            return r;
        end
        ease = (kf_ease[i] == kte_pkg::EASE_BEZIER) ? bezier_ease(kf_ctrl[i], f) : f;
        v = pv + (((nv - pv) * ease) >>> 16);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        r.value = 32'(v);
        return r;
    endfunction

    // sender: one transaction per call
    task automatic send_item(logic op, logic [5:0] slot, logic [39:0] stamp, logic [31:0] kval,
                             logic [1:0] easing, logic [15:0] c1x, logic [15:0] c1y,
                             logic [15:0] c2x, logic [15:0] c2y);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {c2y, c2x, c1y, c1x, easing, kval, stamp, slot};
        do @(posedge aclk); while (!s_tready);
        n_items++;
        if (op == kte_pkg::OP_LOAD) begin
            kf_time[slot] = stamp;
            kf_val[slot] = kval;
            kf_ease[slot] = easing;
            kf_ctrl[slot] = {c2y, c2x, c1y, c1x};
            kf_written[slot] = 1'b1;
        end else begin
            expected_vals.push_back(eval_track(stamp));
        end
    endtask

    task automatic send_rand_load(logic [5:0] slot, logic [39:0] stamp);
        logic [1:0] e;
        e = 2'($urandom_range(3));
        send_item(kte_pkg::OP_LOAD, slot, stamp, $urandom, e, 16'($urandom_range(32768)),
                  16'($urandom), 16'($urandom_range(32768)), 16'($urandom));
    endtask

    task automatic send_eval(logic [39:0] stamp);
        send_item(kte_pkg::OP_EVAL, 6'($urandom), stamp, $urandom, 2'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (expected_vals.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_key_count(int cnt);
        wait_idle();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= 7'(cnt);
        @(negedge aclk);
        cfg_we <= 1'b0;
        kf_count = cnt;
    endtask

    function automatic int written_prefix();
        int p;
        p = 0;
        while (p < 64 && kf_written[p]) p++;
        return p;
    endfunction

    // result side ready
    initial forever begin
        @(negedge aclk);
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 21);
        end
    end

    // result checker
    always @(posedge aclk) begin
        track_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (expected_vals.size() == 0) begin
                $display("%0t: unexpected result value=%h status=%b seg=%0d", $time,
                         m_tdata[31:0], m_tuser, m_tdata[37:32]);
                errors++;
            end else begin
                want = expected_vals.pop_front();
                if (m_tdata[31:0] !== want.value) begin
                    $display("%0t: value expected %h actual %h", $time, want.value, m_tdata[31:0]);
                    errors++;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %b actual %b", $time, want.status, m_tuser);
                    errors++;
                end
                if (m_tdata[37:32] !== want.seg) begin
                    $display("%0t: segment expected %0d actual %0d", $time, want.seg,
                             m_tdata[37:32]);
                    errors++;
                end
            end
        end
    end

    task automatic test_empty_table();
        send_eval(40'd0);
        send_eval(40'hFF_FFFF_FFFF);
        send_eval(40'd12345);
    endtask

    task automatic test_directed_keys();
        send_item(kte_pkg::OP_LOAD, 6'd0, 40'd100, 32'h8000_0000, kte_pkg::EASE_LINEAR, 16'd0,
                  16'h8000, 16'd32768, 16'h7FFF);
        send_item(kte_pkg::OP_LOAD, 6'd1, 40'd200, 32'h7FFF_FFFF, kte_pkg::EASE_LINEAR, 16'd0,
                  16'd0, 16'd0, 16'd0);
        send_item(kte_pkg::OP_LOAD, 6'd2, 40'd300, 32'h8000_0000, kte_pkg::EASE_BEZIER, 16'd0,
                  16'h7FFF, 16'd32768, 16'h8000);
        send_item(kte_pkg::OP_LOAD, 6'd3, 40'd400, 32'h7FFF_FFFF, kte_pkg::EASE_HOLD, 16'd32768,
                  16'h8000, 16'd0, 16'h7FFF);
        send_item(kte_pkg::OP_LOAD, 6'd4, 40'hFF_FFFF_FFFF, 32'h0001_0000, EASE_ALT, 16'd16384,
                  16'h2000, 16'd16384, 16'h2000);
        set_key_count(1);
        send_eval(40'd0);
        send_eval(40'd500);
        set_key_count(5);
        foreach (kf_time[i]) if (i < 5) send_eval(kf_time[i]);
        send_eval(40'd0);
        send_eval(40'd150);
        send_eval(40'd250);
        send_eval(40'd299);
        send_eval(40'd350);
        send_eval(40'd401);
        send_eval(40'hFF_FFFF_FFFE);
        send_eval(40'h80_0000_0000);
    endtask

    // one table: n keys, mostly ascending times, then a burst of queries
    task automatic random_table(int n, int evals, bit wide_times);
        logic [39:0] t, span, q;
        logic [39:0] t0;
        int cnt;
        t = wide_times ? {8'($urandom_range(255)), $urandom} >> 1 : 40'($urandom_range(1000));
        t0 = t;
        for (int s = 0; s < n; s++) begin
            send_rand_load(6'(s), t);
            span = wide_times ? 40'({$urandom_range(127), $urandom}) : 40'($urandom_range(1, 5000));
            if ($urandom_range(19) == 0) span = 0;
            t = t + span;
        end
        if ($urandom_range(9) == 0)
            send_rand_load(6'($urandom_range(n - 1)), {8'($urandom_range(255)), $urandom});
        cnt = ($urandom_range(3) == 0) ? $urandom_range(written_prefix()) : n;
        set_key_count(cnt);
        for (int e = 0; e < evals; e++) begin
            case ($urandom_range(9))
                0: q = kf_time[$urandom_range(n - 1)];
                1: q = {8'($urandom_range(255)), $urandom};
                2: q = t0 - 40'($urandom_range(3));
                default: q = t0 + 40'(({8'd0, $urandom} * 64'(t - t0 + 2)) >> 32);
            endcase
            send_eval(q);
            if ($urandom_range(14) == 0)
                send_rand_load(6'($urandom_range(63)), {8'($urandom_range(255)), $urandom});
        end
    endtask

    task automatic test_random_tables();
        for (int r = 0; r < 30; r++) begin
            no_idle = (r >= 10 && r < 14);
            random_table($urandom_range(2, 12), 25, r % 5 == 4);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_full_table();
        random_table(64, 40, 1'b0);
        set_key_count(64);
        repeat (20) send_eval(kf_time[0] + 40'($urandom_range(400000)));
        set_key_count(127);
        repeat (20) send_eval(kf_time[0] + 40'($urandom_range(400000)));
        set_key_count(65);
        repeat (10) send_eval({8'($urandom_range(255)), $urandom});
    endtask

    task automatic test_output_stall();
        random_table(6, 0, 1'b0);
        hold_left = 300;
        repeat (6) send_eval(kf_time[0] + 40'($urandom_range(30000)));
    endtask

    initial begin
        for (int i = 0; i < 64; i++) kf_written[i] = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_directed_keys();
        test_output_stall();
        test_random_tables();
        test_full_table();
        wait_idle();
        $display("Covered %0d transactions in, %0d results checked: empty, clamped,", n_items,
                 n_results);
        $display("linear, hold and Bezier segments, key counts up to 127, output stalls.");
        if (errors == 0)
            $display("tb_keyframe_track_evaluator_top passed");
        else
            $display("tb_keyframe_track_evaluator_top failed");
        $finish;
    end
endmodule
